/* sv/lmb_pkg.sv */
// Package for the level meter ballistics core.
// Holds the per-channel state layout, register codes, reset values and the
// shared peak/mark update functions. No dependencies.
package lmb_pkg;

    // Meter floor: -90.01 dB in Q8.8
    localparam logic signed [15:0] METER_FLOOR = -16'sd23043;

    // Register reset values
    localparam logic [15:0] FALL_STEP_RST    = 16'd111;
    localparam logic [15:0] HOLD_LIMIT_RST   = 16'd200;
    localparam logic [15:0] AVERAGE_COEF_RST = 16'd30420;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int LEVEL_W          = 16;

    // Packed stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FALL_STEP    = 2'd0,
        CFG_HOLD_LIMIT   = 2'd1,
        CFG_AVERAGE_COEF = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] fall_step;
        logic [15:0] hold_limit;
        logic [15:0] average_coef;
    } cfg_t;

    // Peak mark with its hold counter
    typedef struct packed {
        logic signed [15:0] mark;
        logic [15:0]        cnt;
    } mark_t;

    // Meter state of one side (input or output) of a channel
    typedef struct packed {
        logic signed [15:0] peak_level;
        logic signed [15:0] peak_mark;
        logic [15:0]        hold_cnt;
        logic signed [15:0] max_level;
        logic signed [15:0] average;
    } side_state_t;

    // One memory row: all meter state of one channel
    typedef struct packed {
        logic [15:0]        gr_hold;
        logic signed [15:0] gr_peak;
        side_state_t        side_out;
        side_state_t        side_in;
    } chan_state_t;

    localparam side_state_t SIDE_RESET = '{
        peak_level: METER_FLOOR,
        peak_mark:  METER_FLOOR,
        hold_cnt:   16'd0,
        max_level:  METER_FLOOR,
        average:    METER_FLOOR
    };

    localparam chan_state_t STATE_RESET = '{
        gr_hold:  16'd0,
        gr_peak:  METER_FLOOR,
        side_out: SIDE_RESET,
        side_in:  SIDE_RESET
    };

    // Linear fall by step, never below the current level
    function automatic logic signed [15:0] fall_to(
        input logic signed [15:0] lvl,
        input logic signed [15:0] cur,
        input logic [15:0]        step
    );
        logic signed [17:0] dropped;
        logic signed [17:0] cur_ext;
        dropped = $signed({{2{lvl[15]}}, lvl}) - $signed({2'b00, step});
        cur_ext = $signed({{2{cur[15]}}, cur});
        return (cur_ext > dropped) ? cur : dropped[15:0];
    endfunction

    // Peak mark: rise at once, hold for hold_limit updates, then fall
    function automatic mark_t mark_update(
        input logic signed [15:0] cur,
        input mark_t              prev,
        input logic [15:0]        hold_limit,
        input logic [15:0]        step
    );
        mark_t nxt;
        nxt = prev;
        if (cur >= prev.mark)
        begin
            nxt.mark = cur;
            nxt.cnt  = 16'd0;
        end
        else if (prev.cnt < hold_limit)
        begin
            nxt.cnt = prev.cnt + 16'd1;
        end
        else
        begin
            nxt.mark = fall_to(prev.mark, cur, step);
        end
        return nxt;
    endfunction

endpackage

/* sv/level_meter_ballistics_core.sv */
// Level meter ballistics core: per-channel peak, hold mark, maximum, average
// and gain-reduction peak meters. Depends on lmb_pkg, lmb_cfg, lmb_state_mem
// and lmb_side_update.
//
// Each accepted item updates the meters of one channel and returns one result
// with all of that channel's readings after the update. The block takes one
// item per clock cycle while the result side does not stall; a result passes
// through the update stage and then the output register on its way to the
// master side. The rate is set by the state memory: one row per
// channel, read when the item is transferred and written back when it leaves
// the update stage, with the last write forwarded so that back-to-back items of the same channel
// see each other's update. Row valid bits give the reset readings at once, so
// there is no clearing pass after reset. A channel number at or above
// NUM_CHANNELS updates the last channel, which is what the result reports.
// Configuration writes are taken in any cycle and belong to idle periods.
module level_meter_ballistics_core #(
    parameter int NUM_CHANNELS = lmb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // in_peak_db, out_peak_db, in_rms_db, out_rms_db, gain_reduction_db
    input  logic [lmb_pkg::S_TDATA_W-1:0] s_tdata,
    // channel
    input  logic                          s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // in_peak_level, in_peak_mark, in_max, in_average, out_peak_level,
    // out_peak_mark, out_max, out_average, gr_peak
    output logic [lmb_pkg::M_TDATA_W-1:0] m_tdata,
    // channel_out
    output logic                          m_tuser,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lmb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    lmb_pkg::cfg_t        cfg;
    lmb_pkg::chan_state_t rd_state;
    lmb_pkg::chan_state_t new_state;
    lmb_pkg::mark_t       gr_old;
    lmb_pkg::mark_t       gr_new;

    logic             in_xfer;
    logic             out_free;
    logic             s1_adv;
    logic [CH_AW-1:0] in_ch;

    // Update stage (state read in flight)
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [CH_AW-1:0]   s1_ch_reg;
    logic signed [15:0] s1_in_peak_reg;
    logic signed [15:0] s1_out_peak_reg;
    logic signed [15:0] s1_in_rms_reg;
    logic signed [15:0] s1_out_rms_reg;
    logic signed [15:0] s1_gr_reg;

    // Output register
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [lmb_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    lmb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake and stage control
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_adv;

    assign in_ch = (32'(s_tuser) >= NUM_CHANNELS) ? CH_AW'(NUM_CHANNELS - 1)
                                                   : CH_AW'(s_tuser);

    lmb_state_mem #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (in_ch),
        .rd_data (rd_state),
        .wr_en   (s1_adv),
        .wr_addr (s1_ch_reg),
        .wr_data (new_state)
    );

    // Meter updates for both sides
    lmb_side_update u_side_in (
        .cfg       (cfg),
        .cur_peak  (s1_in_peak_reg),
        .cur_rms   (s1_in_rms_reg),
        .old_state (rd_state.side_in),
        .new_state (new_state.side_in)
    );

    lmb_side_update u_side_out (
        .cfg       (cfg),
        .cur_peak  (s1_out_peak_reg),
        .cur_rms   (s1_out_rms_reg),
        .old_state (rd_state.side_out),
        .new_state (new_state.side_out)
    );

    // Gain-reduction peak: a mark without the 0 dB clamp
    assign gr_old.mark = rd_state.gr_peak;
    assign gr_old.cnt  = rd_state.gr_hold;
    assign gr_new      = lmb_pkg::mark_update(s1_gr_reg, gr_old,
                                              cfg.hold_limit, cfg.fall_step);
    assign new_state.gr_peak = gr_new.mark;
    assign new_state.gr_hold = gr_new.cnt;

    // Stage valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (s1_adv)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ch_reg       <= in_ch;
            s1_in_peak_reg  <= s_tdata[15:0];
            s1_out_peak_reg <= s_tdata[31:16];
            s1_in_rms_reg   <= s_tdata[47:32];
            s1_out_rms_reg  <= s_tdata[63:48];
            s1_gr_reg       <= s_tdata[79:64];
        end
        if (s1_adv)
        begin
            m_tuser_reg <= 1'(s1_ch_reg);
            m_tdata_reg <= {new_state.gr_peak,
                            new_state.side_out.average,
                            new_state.side_out.max_level,
                            new_state.side_out.peak_mark,
                            new_state.side_out.peak_level,
                            new_state.side_in.average,
                            new_state.side_in.max_level,
                            new_state.side_in.peak_mark,
                            new_state.side_in.peak_level};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A stalled item stays in the update stage until it can be written back
    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("update stage lost a stalled item");

    // State is written back only when the result has a place to go
    a_wb_gate : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid_reg)
        else $error("write-back without a result transfer slot");

    // Peak readings never exceed 0 dB
    a_peak_clamp : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd0
                      && $signed(m_tdata[79:64]) <= 16'sd0))
        else $error("peak reading above 0 dB");

    // The maximum is never below the peak reading
    a_max_peak : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[47:32]) >= $signed(m_tdata[15:0])
                      && $signed(m_tdata[111:96]) >= $signed(m_tdata[79:64])))
        else $error("maximum below peak reading");

endmodule

/* sv/lmb_cfg.sv */
// Configuration registers of the level meter ballistics core.
// Decodes the write channel into fall step, hold limit and average coefficient.
// Depends on lmb_pkg.
module lmb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lmb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output lmb_pkg::cfg_t                 cfg
);

    lmb_pkg::cfg_t cfg_reg;
    lmb_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (lmb_pkg::cfg_index_t'(cfg_index))
                lmb_pkg::CFG_FALL_STEP:    cfg_next.fall_step    = cfg_data;
                lmb_pkg::CFG_HOLD_LIMIT:   cfg_next.hold_limit   = cfg_data;
                lmb_pkg::CFG_AVERAGE_COEF: cfg_next.average_coef = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fall_step    <= lmb_pkg::FALL_STEP_RST;
            cfg_reg.hold_limit   <= lmb_pkg::HOLD_LIMIT_RST;
            cfg_reg.average_coef <= lmb_pkg::AVERAGE_COEF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/lmb_state_mem.sv */
// Per-channel state memory: one row per channel, registered read,
// row valid bits for the reset value and forwarding of the last write.
// Depends on lmb_pkg.
module lmb_state_mem #(
    parameter int NUM_CHANNELS = lmb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
    output lmb_pkg::chan_state_t rd_data,
    input  logic                 wr_en,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] wr_addr,
    input  lmb_pkg::chan_state_t wr_data
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    lmb_pkg::chan_state_t mem [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [CH_AW-1:0]        rd_addr_reg;
    lmb_pkg::chan_state_t    rd_data_reg;

    // Last write, kept for a read that was issued in the same cycle
    logic                    wb_valid_reg;
    logic [CH_AW-1:0]        wb_addr_reg;
    lmb_pkg::chan_state_t    wb_data_reg;

    // Memory array: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            wb_data_reg <= wr_data;
            wb_addr_reg <= wr_addr;
        end
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    // Valid bits: a row never written reads as the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
                wb_valid_reg           <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Read data with forwarding: the last write is always the newest copy
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == rd_addr_reg))
        begin
            rd_data = wb_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = rd_data_reg;
        end
        else
        begin
            rd_data = lmb_pkg::STATE_RESET;
        end
    end

endmodule

/* sv/lmb_side_update.sv */
// Meter update of one side of a channel: maximum, peak reading, peak mark
// and one-pole average. Depends on lmb_pkg.
module lmb_side_update (
    input  lmb_pkg::cfg_t        cfg,
    input  logic signed [15:0]   cur_peak,
    input  logic signed [15:0]   cur_rms,
    input  lmb_pkg::side_state_t old_state,
    output lmb_pkg::side_state_t new_state
);

    lmb_pkg::mark_t     mark_old;
    lmb_pkg::mark_t     mark_new;
    logic signed [16:0] avg_diff;
    logic signed [33:0] avg_prod;
    logic signed [33:0] avg_round;
    logic signed [17:0] avg_sum;

    // Peak mark, forced to 0 dB on a clipping level
    always_comb
    begin
        mark_old.mark = old_state.peak_mark;
        mark_old.cnt  = old_state.hold_cnt;
        if (cur_peak >= 16'sd0)
        begin
            mark_new.mark = 16'sd0;
            mark_new.cnt  = 16'd0;
        end
        else
        begin
            mark_new = lmb_pkg::mark_update(cur_peak, mark_old,
                                            cfg.hold_limit, cfg.fall_step);
        end
    end

    // Average: level + round(coef * (old - level) / 2^16), half up
    assign avg_diff  = $signed({old_state.average[15], old_state.average})
                     - $signed({cur_rms[15], cur_rms});
    assign avg_prod  = $signed({1'b0, cfg.average_coef}) * avg_diff;
    assign avg_round = avg_prod + 34'sd32768;
    assign avg_sum   = $signed(avg_round[33:16]) + $signed({{2{cur_rms[15]}}, cur_rms});

    always_comb
    begin
        new_state = old_state;

        // Maximum only rises
        if (cur_peak > old_state.max_level)
        begin
            new_state.max_level = cur_peak;
        end

        // Peak reading
        if (cur_peak >= 16'sd0)
        begin
            new_state.peak_level = 16'sd0;
        end
        else if (cur_peak >= old_state.peak_level)
        begin
            new_state.peak_level = cur_peak;
        end
        else
        begin
            new_state.peak_level = lmb_pkg::fall_to(old_state.peak_level, cur_peak,
                                                    cfg.fall_step);
        end

        new_state.peak_mark = mark_new.mark;
        new_state.hold_cnt  = mark_new.cnt;
        new_state.average   = avg_sum[15:0];
    end

endmodule

/* test/tb_level_meter_ballistics_core.sv */
`timescale 1ns / 100ps
// Testbench for level_meter_ballistics_core: streams metering windows under a
// series of register settings and checks every readout against its own meter
// predictor. Depends on lmb_pkg and the core RTL.
module tb_level_meter_ballistics_core;
    import lmb_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_WINDOWS = 125;
    localparam int NUM_PHASES    = 12;
    localparam int REPORT_LIMIT  = 10;
    localparam int NUM_READINGS  = 9;
    // Index past the register list; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                 channel;
        logic [S_TDATA_W-1:0] levels;
    } window_t;

    typedef struct packed {
        logic                 channel;
        logic [M_TDATA_W-1:0] readings;
    } readout_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // in_peak_db, out_peak_db, in_rms_db, out_rms_db, gain_reduction_db
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // channel
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // in_peak_level, in_peak_mark, in_max, in_average, out_peak_level,
    // out_peak_mark, out_max, out_average, gr_peak
    logic [M_TDATA_W-1:0] m_tdata;
    // channel_out
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // Predicted meter state, index 2*channel + side (0 input, 1 output)
    logic signed [15:0] meter_peak [4];
    logic signed [15:0] meter_mark [4];
    logic [15:0]        meter_hold [4];
    logic signed [15:0] meter_max  [4];
    logic signed [15:0] meter_avg  [4];
    logic signed [15:0] gr_mark    [2];
    logic [15:0]        gr_hold    [2];
    logic [15:0]        fall_step_r;
    logic [15:0]        hold_limit_r;
    logic [15:0]        avg_coef_r;

    window_t  pending_windows[$];
    readout_t expected_readouts[$];
    window_t  next_window;
    readout_t predicted;

    int level_walk[2];
    int gr_walk[2];
    int send_gap       = 0;
    int send_gap_max   = 0;
    int recv_stall     = 0;
    int recv_stall_max = 0;
    int stall_draw;
    int error_count     = 0;
    int windows_done    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;

    level_meter_ballistics_core #(
        .NUM_CHANNELS(NUM_CHANNELS_DEF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("level_meter_ballistics_core verification failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // Linear fall by the step, floored at the current level
    function automatic logic signed [15:0] decay_toward(
        input logic signed [15:0] from_lvl,
        input logic signed [15:0] cur
    );
        int dropped;
        dropped = int'(from_lvl) - int'(fall_step_r);
        return (int'(cur) > dropped) ? cur : 16'(dropped);
    endfunction

    // One-pole average, product rounded half up
    function automatic logic signed [15:0] smooth_average(
        input logic signed [15:0] prev,
        input logic signed [15:0] lvl
    );
        longint prod;
        prod = longint'(avg_coef_r) * (longint'(prev) - longint'(lvl)) + 32768;
        return 16'(longint'(lvl) + (prod >>> 16));
    endfunction

    // Mark: rise at once, hold while the count is below the limit, then fall
    task automatic track_mark(
        input logic signed [15:0] cur,
        inout logic signed [15:0] mark,
        inout logic [15:0]        cnt
    );
        if (cur >= mark)
        begin
            mark = cur;
            cnt  = '0;
        end
        else if (cnt < hold_limit_r)
            cnt = cnt + 16'd1;
        else
            mark = decay_toward(mark, cur);
    endtask

    // Peak reading and mark, both pinned to 0 dB at or above full scale
    task automatic track_peak(
        input logic signed [15:0] cur,
        inout logic signed [15:0] lvl,
        inout logic signed [15:0] mark,
        inout logic [15:0]        cnt
    );
        if (cur >= 16'sd0)
        begin
            lvl  = '0;
            mark = '0;
            cnt  = '0;
        end
        else
        begin
            if (cur >= lvl)
                lvl = cur;
            else
                lvl = decay_toward(lvl, cur);
            track_mark(cur, mark, cnt);
        end
    endtask

    // Meter update for one window; returns the channel's readings afterwards
    task automatic predict_window(input window_t w, output readout_t r);
        logic signed [15:0] pk  [2];
        logic signed [15:0] rms [2];
        int k;
        int s;
        r       = '0;
        pk[0]   = w.levels[15:0];
        pk[1]   = w.levels[31:16];
        rms[0]  = w.levels[47:32];
        rms[1]  = w.levels[63:48];
        r.channel = w.channel;
        for (s = 0; s < 2; s++)
        begin
            k = 2 * int'(w.channel) + s;
            if (pk[s] > meter_max[k])
                meter_max[k] = pk[s];
            track_peak(pk[s], meter_peak[k], meter_mark[k], meter_hold[k]);
            meter_avg[k] = smooth_average(meter_avg[k], rms[s]);
            r.readings[64*s +: 64] = {meter_avg[k], meter_max[k], meter_mark[k],
                                      meter_peak[k]};
        end
        track_mark(w.levels[79:64], gr_mark[w.channel], gr_hold[w.channel]);
        r.readings[143:128] = gr_mark[w.channel];
    endtask

    function automatic string reading_name(input int i);
        case (i)
            0: return "in_peak_level";
            1: return "in_peak_mark";
            2: return "in_max";
            3: return "in_average";
            4: return "out_peak_level";
            5: return "out_peak_mark";
            6: return "out_max";
            7: return "out_average";
            default: return "gr_peak";
        endcase
    endfunction

    task automatic check_readout(input logic ch, input logic [M_TDATA_W-1:0] got);
        readout_t want;
        int i;
        if (expected_readouts.size() == 0)
        begin
            if (error_count < REPORT_LIMIT)
                $display("ERROR: readout for channel %0d with none pending", ch);
            error_count++;
            return;
        end
        want = expected_readouts.pop_front();
        results_checked++;
        if (ch !== want.channel)
        begin
            if (error_count < REPORT_LIMIT)
                $display("MISMATCH channel_out: expected %0d, got %0d", want.channel, ch);
            error_count++;
        end
        for (i = 0; i < NUM_READINGS; i++)
        begin
            if (got[16*i +: 16] !== want.readings[16*i +: 16])
            begin
                if (error_count < REPORT_LIMIT)
                    $display("MISMATCH %s (readout %0d, channel %0d): expected %0d, got %0d",
                             reading_name(i), results_checked, want.channel,
                             $signed(want.readings[16*i +: 16]), $signed(got[16*i +: 16]));
                error_count++;
            end
        end
    endtask

    // Input driver: one window per transfer, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_window({s_tuser, s_tdata}, predicted);
                expected_readouts.push_back(predicted);
                windows_done++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_windows.size() != 0)
                begin
                    next_window = pending_windows.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_window.levels;
                    s_tuser  <= next_window.channel;
                    send_gap <= $urandom_range(0, send_gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: check each transfer, then stall a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_readout(m_tuser, m_tdata);
                stall_draw = $urandom_range(0, recv_stall_max);
                if (stall_draw != 0)
                begin
                    m_tready   <= 1'b0;
                    recv_stall <= stall_draw;
                end
            end
            else if (recv_stall > 1)
                recv_stall <= recv_stall - 1;
            else
            begin
                recv_stall <= 0;
                m_tready   <= 1'b1;
            end
        end
    end

    task automatic add_window(input int ch, input int ip, input int op, input int irms,
                              input int orms, input int gr);
        window_t w;
        w.channel = ch[0];
        w.levels  = {clamp16(gr), clamp16(orms), clamp16(irms), clamp16(op), clamp16(ip)};
        pending_windows.push_back(w);
    endtask

    // Mostly a drifting program level per channel, some pure noise windows
    task automatic add_random_window();
        window_t w;
        int ch;
        int base;
        ch = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
        begin
            w.channel = ch[0];
            w.levels  = {16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom())};
            pending_windows.push_back(w);
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                level_walk[ch] = int'($urandom_range(0, 28000)) - 26000;
            else
                level_walk[ch] = clamp16(level_walk[ch] + int'($urandom_range(0, 1200)) - 600);
            gr_walk[ch] = clamp16(gr_walk[ch] + int'($urandom_range(0, 160)) - 80);
            base = level_walk[ch];
            add_window(ch, base + int'($urandom_range(0, 500)),
                       base - int'($urandom_range(0, 1500)),
                       base - int'($urandom_range(0, 3000)),
                       base - int'($urandom_range(0, 4000)), gr_walk[ch]);
        end
    endtask

    // Leaves cfg_valid high so back-to-back writes need no low pulse
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FALL_STEP:    fall_step_r  = val;
            CFG_HOLD_LIMIT:   hold_limit_r = val;
            CFG_AVERAGE_COEF: avg_coef_r   = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_windows.size() != 0 || s_tvalid || expected_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int i;
        int phase;
        logic [15:0] new_fall;
        logic [15:0] new_hold;
        logic [15:0] new_coef;

        for (i = 0; i < 4; i++)
        begin
            meter_peak[i] = METER_FLOOR;
            meter_mark[i] = METER_FLOOR;
            meter_hold[i] = '0;
            meter_max[i]  = METER_FLOOR;
            meter_avg[i]  = METER_FLOOR;
        end
        for (i = 0; i < 2; i++)
        begin
            gr_mark[i]    = METER_FLOOR;
            gr_hold[i]    = '0;
            level_walk[i] = -20000;
            gr_walk[i]    = -500;
        end
        fall_step_r  = FALL_STEP_RST;
        hold_limit_r = HOLD_LIMIT_RST;
        avg_coef_r   = AVERAGE_COEF_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed windows under reset settings, back to back
        send_gap_max   = 0;
        recv_stall_max = 2;
        add_window(0, -23043, -23043, -23043, -23043, -23043);
        add_window(0, 0, 32767, 0, 32767, 32767);
        add_window(0, -1, -32768, -32768, -1, -32768);
        add_window(0, -32768, -32768, 32767, -32768, 0);
        add_window(1, -32768, -32768, -32768, -32768, -32768);
        add_window(1, 32767, 0, -32768, 32767, -32767);
        add_window(1, -1, -1, -1, -1, -1);
        add_window(1, 256, -256, 1, -2, 1);
        add_window(0, 21845, -21846, 21845, -21846, 21845);
        add_window(1, -21846, 21845, -21846, 21845, -21846);
        // Channel 0 peaks fall (readings drop by at most the step while marks hold), channel 1 in peaks rise
        for (i = 0; i < 6; i++)
            add_window(0, -6000 - 50 * i, -6000 - 300 * i, -6000, -7000 + i, -100 - i);
        for (i = 0; i < 4; i++)
            add_window(1, -12000 + 20 * i, -30000, 32767 - i, -32768 + i, -50);
        wait_idle();

        // Setting phases: extremes first, then random
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    new_fall = 16'd0;
                    new_hold = 16'd0;
                    new_coef = 16'd0;
                end
                1:
                begin
                    new_fall = 16'hffff;
                    new_hold = 16'hffff;
                    new_coef = 16'hffff;
                end
                2:
                begin
                    new_fall = 16'd1;
                    new_hold = 16'd1;
                    new_coef = 16'h8000;
                end
                default:
                begin
                    new_fall = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                           : 16'($urandom_range(1, 1500));
                    new_hold = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                           : 16'($urandom_range(0, 10));
                    new_coef = 16'($urandom());
                end
            endcase
            write_register(CFG_FALL_STEP, new_fall);
            write_register(CFG_HOLD_LIMIT, new_hold);
            write_register(CFG_AVERAGE_COEF, new_coef);
            write_register(CFG_UNUSED, 16'($urandom()));
            cfg_valid <= 1'b0;

            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            repeat (PHASE_WINDOWS) add_random_window();
            wait_idle();
        end

        $display("Checked %0d readouts from %0d metering windows over two channels",
                 results_checked, windows_done);
        $display("%0d register writes across %0d settings, extremes and an unused index included",
                 cfg_writes, NUM_PHASES + 1);
        if (error_count == 0 && expected_readouts.size() == 0)
            $display("level_meter_ballistics_core verification clean");
        else
            $display("level_meter_ballistics_core verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/lmb_pkg.sv
sv/lmb_cfg.sv
sv/lmb_state_mem.sv
sv/lmb_side_update.sv
sv/level_meter_ballistics_core.sv
test/tb_level_meter_ballistics_core.sv
